### design/word_frequency_table_top_assert.svh
// assertion macros used by the table search of the word frequency table design
`ifndef WORD_FREQUENCY_TABLE_TOP_ASSERT_SVH
`define WORD_FREQUENCY_TABLE_TOP_ASSERT_SVH

// condition must never hold while out of reset
`define WFT_ASSERT_NEVER(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

// antecedent implies consequent in the same cycle
`define WFT_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("implication failed");

`endif

### design/wft_pkg.sv
// ----------------------------------------------------------------------------
// wft_pkg
// shared types and constants of the word frequency table
// ----------------------------------------------------------------------------
package wft_pkg;

    localparam int unsigned INDEX_W = 12;
    localparam int unsigned COUNT_W = 24;
    localparam logic [COUNT_W-1:0] COUNT_MAX = 24'hFFFFFF;

    localparam int unsigned PADDR_W = 5;

    // register indexes
    localparam logic [2:0] REG_DELIM_A = 3'd0;
    localparam logic [2:0] REG_DELIM_B = 3'd1;
    localparam logic [2:0] REG_DELIM_C = 3'd2;
    localparam logic [2:0] REG_DELIM_D = 3'd3;
    localparam logic [2:0] REG_DELIM_E = 3'd4;

    // delimiter reset values
    localparam logic [7:0] DELIM_A_RST = 8'd44;
    localparam logic [7:0] DELIM_B_RST = 8'd46;
    localparam logic [7:0] DELIM_C_RST = 8'd63;
    localparam logic [7:0] DELIM_D_RST = 8'd58;
    localparam logic [7:0] DELIM_E_RST = 8'd32;

    typedef struct packed {
        logic [7:0] a;
        logic [7:0] b;
        logic [7:0] c;
        logic [7:0] d;
        logic [7:0] e;
    } delims_t;

    typedef struct packed {
        logic [INDEX_W-1:0] index;
        logic [COUNT_W-1:0] count;
        logic               is_new;
        logic               full;
        logic               truncated;
        logic [COUNT_W-1:0] total;
    } result_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_READ,
        S_CMP,
        S_MISS
    } back_state_t;

endpackage

### design/wft_front.sv
// ----------------------------------------------------------------------------
// wft_front
// splits the byte stream into words and pushes each closed word
// ----------------------------------------------------------------------------
module wft_front #(
    parameter int unsigned WORD_CHARS = 19,
    parameter int unsigned LEN_W      = 5
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      accept,
    input  logic [7:0]                text_byte,
    input  logic                      end_of_text,
    input  wft_pkg::delims_t          delims,
    output logic                      push,
    output logic [WORD_CHARS*8-1:0]   word_chars,
    output logic [LEN_W-1:0]          word_len,
    output logic                      word_cut
);
    import wft_pkg::*;

    logic [WORD_CHARS*8-1:0] chars_reg;
    logic [LEN_W-1:0]        len_reg, len_next;
    logic                    cut_reg, cut_next;
    logic                    is_delim;
    logic                    word_open;
    logic                    add_char;

    assign is_delim  = end_of_text || text_byte == delims.a || text_byte == delims.b
                     || text_byte == delims.c || text_byte == delims.d
                     || text_byte == delims.e;
    assign word_open = (len_reg != '0) || cut_reg;
    assign push      = accept && is_delim && word_open;
    assign add_char  = accept && !is_delim && (len_reg < LEN_W'(WORD_CHARS));

    always_comb
    begin
        len_next = len_reg;
        cut_next = cut_reg;
        if (accept)
        begin
            if (is_delim)
            begin
                len_next = '0;
                cut_next = 1'b0;
            end
            else if (add_char)
            begin
                len_next = len_reg + LEN_W'(1);
            end
            else
            begin
                cut_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_reg <= '0;
            cut_reg <= 1'b0;
        end
        else
        begin
            len_reg <= len_next;
            cut_reg <= cut_next;
        end
    end

    // byte lanes of the open word
    for (genvar i = 0; i < WORD_CHARS; i++)
    begin : g_lane
        always_ff @(posedge clk)
        begin
            if (add_char && len_reg == LEN_W'(i))
            begin
                chars_reg[i*8 +: 8] <= text_byte;
            end
        end
    end

    assign word_chars = chars_reg;
    assign word_len   = len_reg;
    assign word_cut   = cut_reg;

endmodule

### design/wft_fifo.sv
// ----------------------------------------------------------------------------
// wft_fifo
// two-entry queue between the word splitter and the table search
// ----------------------------------------------------------------------------
module wft_fifo #(
    parameter int unsigned WIDTH = 158
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] wdata,
    input  logic             pop,
    output logic [WIDTH-1:0] rdata,
    output logic             full,
    output logic             empty
);
    import wft_pkg::*;

    logic [WIDTH-1:0] data_reg [2];
    logic             wr_ptr_reg, rd_ptr_reg;
    logic [1:0]       count_reg, count_next;

    assign full  = count_reg == 2'd2;
    assign empty = count_reg == 2'd0;
    assign rdata = data_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            count_reg <= count_next;
            if (push)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            data_reg[wr_ptr_reg] <= wdata;
        end
    end

endmodule

### design/wft_back.sv
// ----------------------------------------------------------------------------
// wft_back
// searches the distinct-word table one entry at a time and updates it
// ----------------------------------------------------------------------------
module wft_back #(
    parameter int unsigned TABLE_ENTRIES = 4096,
    parameter int unsigned WORD_CHARS    = 19,
    parameter int unsigned LEN_W         = 5,
    parameter int unsigned IDX_W         = 12
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    q_empty,
    input  logic [WORD_CHARS*8-1:0] q_chars,
    input  logic [LEN_W-1:0]        q_len,
    input  logic                    q_cut,
    output logic                    pop,
    output logic                    result_valid,
    output wft_pkg::result_t        result
);
    import wft_pkg::*;

    localparam int unsigned CW = WORD_CHARS * 8;
    localparam int unsigned RW = CW + LEN_W + COUNT_W;

    logic [RW-1:0]       mem [TABLE_ENTRIES];
    logic [RW-1:0]       rdata_reg;

    back_state_t         state_reg, state_next;
    logic [CW-1:0]       wchars_reg;
    logic [LEN_W-1:0]    wlen_reg;
    logic                wcut_reg;
    logic [IDX_W:0]      scan_reg, scan_next;
    logic [IDX_W:0]      used_reg, used_next;
    logic [COUNT_W-1:0]  total_reg, total_next;
    result_t             result_reg, result_next;
    logic                strobe_reg, strobe_next;

    logic                hit;
    logic                room;
    logic                mem_we;
    logic [IDX_W-1:0]    mem_waddr;
    logic [RW-1:0]       mem_wdata;
    logic [CW-1:0]       row_chars;
    logic [LEN_W-1:0]    row_len;
    logic [COUNT_W-1:0]  row_count;
    logic [COUNT_W-1:0]  count_inc;
    logic [WORD_CHARS-1:0] lane_ok;

    assign row_chars = rdata_reg[RW-1 -: CW];
    assign row_len   = rdata_reg[COUNT_W +: LEN_W];
    assign row_count = rdata_reg[COUNT_W-1:0];
    assign count_inc = (row_count == COUNT_MAX) ? row_count : row_count + COUNT_W'(1);
    assign room      = used_reg != (IDX_W+1)'(TABLE_ENTRIES);

    // only the first wlen bytes take part in the compare
    for (genvar i = 0; i < WORD_CHARS; i++)
    begin : g_cmp
        assign lane_ok[i] = (wlen_reg <= LEN_W'(i))
                          || (row_chars[i*8 +: 8] == wchars_reg[i*8 +: 8]);
    end
    assign hit = (row_len == wlen_reg) && (&lane_ok);

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (!q_empty)
                begin
                    state_next = S_READ;
                end
            end
            S_READ:
            begin
                state_next = (scan_reg == used_reg) ? S_MISS : S_CMP;
            end
            S_CMP:
            begin
                state_next = hit ? S_IDLE : S_READ;
            end
            S_MISS:
            begin
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // outputs and datapath
    always_comb
    begin
        pop         = 1'b0;
        scan_next   = scan_reg;
        used_next   = used_reg;
        total_next  = total_reg;
        result_next = result_reg;
        strobe_next = 1'b0;
        mem_we      = 1'b0;
        mem_waddr   = scan_reg[IDX_W-1:0];
        mem_wdata   = {wchars_reg, wlen_reg, count_inc};
        case (state_reg)
            S_IDLE:
            begin
                if (!q_empty)
                begin
                    pop        = 1'b1;
                    scan_next  = '0;
                    total_next = (total_reg == COUNT_MAX) ? total_reg
                                                          : total_reg + COUNT_W'(1);
                end
            end
            S_READ:
            begin
            end
            S_CMP:
            begin
                if (hit)
                begin
                    mem_we      = 1'b1;
                    strobe_next = 1'b1;
                    result_next = '{index: INDEX_W'(scan_reg), count: count_inc,
                                    is_new: 1'b0, full: 1'b0,
                                    truncated: wcut_reg, total: total_reg};
                end
                else
                begin
                    scan_next = scan_reg + (IDX_W+1)'(1);
                end
            end
            S_MISS:
            begin
                strobe_next = 1'b1;
                if (room)
                begin
                    mem_we      = 1'b1;
                    mem_waddr   = used_reg[IDX_W-1:0];
                    mem_wdata   = {wchars_reg, wlen_reg, COUNT_W'(1)};
                    used_next   = used_reg + (IDX_W+1)'(1);
                    result_next = '{index: INDEX_W'(used_reg), count: COUNT_W'(1),
                                    is_new: 1'b1, full: 1'b0,
                                    truncated: wcut_reg, total: total_reg};
                end
                else
                begin
                    result_next = '{index: '0, count: '0, is_new: 1'b0, full: 1'b1,
                                    truncated: wcut_reg, total: total_reg};
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            scan_reg   <= '0;
            used_reg   <= '0;
            total_reg  <= '0;
            strobe_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            scan_reg   <= scan_next;
            used_reg   <= used_next;
            total_reg  <= total_next;
            strobe_reg <= strobe_next;
        end
    end

    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
        if (pop)
        begin
            wchars_reg <= q_chars;
            wlen_reg   <= q_len;
            wcut_reg   <= q_cut;
        end
    end

    // table memory, registered read
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (state_reg == S_READ)
        begin
            rdata_reg <= mem[scan_reg[IDX_W-1:0]];
        end
    end

    assign result_valid = strobe_reg;
    assign result       = result_reg;

`include "word_frequency_table_top_assert.svh"
    `WFT_ASSERT_NEVER(a_new_and_full, clk, rst_n, strobe_reg && result_reg.is_new && result_reg.full, "new word flagged while table full")
    `WFT_ASSERT_NEVER(a_used_bound, clk, rst_n, used_reg > (IDX_W+1)'(TABLE_ENTRIES), "table fill beyond capacity")
    `WFT_ASSERT_IMPLY(a_strobe_idle, clk, rst_n, strobe_reg, state_reg == S_IDLE)
    `WFT_ASSERT_NEVER(a_scan_bound, clk, rst_n, scan_reg > used_reg, "search ran past the filled entries")

endmodule

### design/word_frequency_table_top.sv
// ----------------------------------------------------------------------------
// word_frequency_table_top
// counts distinct words of a byte stream in a table of entries
// ----------------------------------------------------------------------------
//  channel   signals                                  direction
//  input     start, busy, text_byte, end_of_text      in (busy out)
//  result    result_valid, entry_index .. words_total out, one-cycle strobe
//  config    psel, penable, pwrite, paddr, pwdata,     apb slave, 5 delimiters
//            prdata, pready
//
//  a byte is taken in any cycle with start high and busy low; busy rises
//  only while the two-word queue is full. each closed word is searched
//  entry by entry (read, compare) as the table memory has a single read
//  port; the strobe is registered from the hit compare or the miss state.
//  after reset the table is empty at once (fill count, no clearing pass).
//  results cannot be stalled; a strobe lasts one cycle.
// ----------------------------------------------------------------------------
module word_frequency_table_top #(
    parameter int unsigned TABLE_ENTRIES = 4096,
    parameter int unsigned WORD_CHARS    = 19
) (
    input  logic                         clk,
    input  logic                         rst_n,
    // input words
    input  logic                         start,
    output logic                         busy,
    input  logic [7:0]                   text_byte,
    input  logic                         end_of_text,
    // results
    output logic                         result_valid,
    output logic [wft_pkg::INDEX_W-1:0]  entry_index,
    output logic [wft_pkg::COUNT_W-1:0]  entry_count,
    output logic                         is_new_word,
    output logic                         table_full,
    output logic                         word_truncated,
    output logic [wft_pkg::COUNT_W-1:0]  words_total,
    // configuration
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [wft_pkg::PADDR_W-1:0]  paddr,
    input  logic [31:0]                  pwdata,
    output logic [31:0]                  prdata,
    output logic                         pready
);
    import wft_pkg::*;

    localparam int unsigned LEN_W = $clog2(WORD_CHARS + 1);
    localparam int unsigned IDX_W = $clog2(TABLE_ENTRIES);
    localparam int unsigned QW    = WORD_CHARS * 8 + LEN_W + 1;

    delims_t                 delims_reg;
    logic [2:0]              reg_idx;
    logic                    cfg_wr;
    logic                    accept;
    logic                    push;
    logic                    pop;
    logic                    q_full, q_empty;
    logic [WORD_CHARS*8-1:0] f_chars;
    logic [LEN_W-1:0]        f_len;
    logic                    f_cut;
    logic [QW-1:0]           q_rdata;
    result_t                 result;

    // apb register file, zero wait states
    assign pready  = 1'b1;
    assign reg_idx = paddr[4:2];
    assign cfg_wr  = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            delims_reg <= '{a: DELIM_A_RST, b: DELIM_B_RST, c: DELIM_C_RST,
                            d: DELIM_D_RST, e: DELIM_E_RST};
        end
        else if (cfg_wr)
        begin
            case (reg_idx)
                REG_DELIM_A: delims_reg.a <= pwdata[7:0];
                REG_DELIM_B: delims_reg.b <= pwdata[7:0];
                REG_DELIM_C: delims_reg.c <= pwdata[7:0];
                REG_DELIM_D: delims_reg.d <= pwdata[7:0];
                REG_DELIM_E: delims_reg.e <= pwdata[7:0];
                default:     ;
            endcase
        end
    end

    always_comb
    begin
        case (reg_idx)
            REG_DELIM_A: prdata = {24'd0, delims_reg.a};
            REG_DELIM_B: prdata = {24'd0, delims_reg.b};
            REG_DELIM_C: prdata = {24'd0, delims_reg.c};
            REG_DELIM_D: prdata = {24'd0, delims_reg.d};
            REG_DELIM_E: prdata = {24'd0, delims_reg.e};
            default:     prdata = 32'd0;
        endcase
    end

    // a closed word always finds room in the queue while busy is low
    assign busy   = q_full;
    assign accept = start && !busy;

    wft_front #(
        .WORD_CHARS (WORD_CHARS),
        .LEN_W      (LEN_W)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .accept      (accept),
        .text_byte   (text_byte),
        .end_of_text (end_of_text),
        .delims      (delims_reg),
        .push        (push),
        .word_chars  (f_chars),
        .word_len    (f_len),
        .word_cut    (f_cut)
    );

    wft_fifo #(
        .WIDTH (QW)
    ) u_fifo (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .wdata ({f_chars, f_len, f_cut}),
        .pop   (pop),
        .rdata (q_rdata),
        .full  (q_full),
        .empty (q_empty)
    );

    wft_back #(
        .TABLE_ENTRIES (TABLE_ENTRIES),
        .WORD_CHARS    (WORD_CHARS),
        .LEN_W         (LEN_W),
        .IDX_W         (IDX_W)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .q_empty      (q_empty),
        .q_chars      (q_rdata[QW-1 -: WORD_CHARS*8]),
        .q_len        (q_rdata[LEN_W:1]),
        .q_cut        (q_rdata[0]),
        .pop          (pop),
        .result_valid (result_valid),
        .result       (result)
    );

    // result fields
    assign entry_index    = result.index;
    assign entry_count    = result.count;
    assign is_new_word    = result.is_new;
    assign table_full     = result.full;
    assign word_truncated = result.truncated;
    assign words_total    = result.total;

endmodule
